### hdl/lookahead_peak_limiter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lookahead peak limiter
// ---------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPL_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("limiter assertion failed");

// Next-cycle implication, disabled during reset.
`define LPL_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("limiter assertion failed");

`endif

### hdl/lpl_pkg.sv
// ---------------------------------------------------------------------------
// lpl_pkg
// Shared widths, register indexes and the fixed root table for dB-to-linear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lpl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 17;
  localparam int LA_W     = 10;
  localparam int COEF_W   = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

  localparam logic [IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd3;

  // 1/(20*log10(2)) in Q.20
  localparam logic [17:0] LOG2_PER_DB = 18'd174165;

  typedef logic [30:0] root_arr_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > n) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.30 values of 2^(-2^-k), k = 1..16
  function automatic root_arr_t build_roots();
    root_arr_t t;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      t[k] = c[30:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam root_arr_t ROOT_TABLE = build_roots();

endpackage
`default_nettype wire

### hdl/lookahead_peak_limiter.sv
// ---------------------------------------------------------------------------
// lookahead_peak_limiter
// Envelope follower, lookahead delay memory and hard-knee gain stage.
// ---------------------------------------------------------------------------
// Channel  | Handshake           | Payload
// input    | in_valid/in_ready   | sample_in
// output   | out_valid/out_ready | sample_out, gain_applied
// config   | cfg_write           | cfg_index, cfg_data
//
// One request at a time; the 17-step gain divider runs for each request
// unless the gain is unity (zero envelope or quotient of two or more) and it is skipped.
// After a threshold write the next request first runs the dB-to-linear
// product chain (two partial products per fraction bit).
// Reset (rst, synchronous) clears control state; no memory clearing pass.
// A finished result waits in the output register; a new request is taken
// meanwhile and stalls only at its final output step.
`timescale 1ns / 1ps
`default_nettype none
module lookahead_peak_limiter #(
  parameter int DELAY_DEPTH = 1024
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [lpl_pkg::SAMPLE_W-1:0] sample_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [lpl_pkg::SAMPLE_W-1:0] sample_out,
  output logic [lpl_pkg::GAIN_W-1:0]       gain_applied,
  input  wire                              cfg_write,
  input  wire [lpl_pkg::IDX_W-1:0]         cfg_index,
  input  wire [lpl_pkg::CFG_W-1:0]         cfg_data
);
  import lpl_pkg::*;

  localparam int AW     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int DW     = ((AW > LA_W) ? AW : LA_W) + 1;
  localparam int LA_MAX = (DELAY_DEPTH < 1023) ? DELAY_DEPTH : 1023;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ENV     = 4'd1;
  localparam logic [3:0] S_THR_X   = 4'd2;
  localparam logic [3:0] S_THR_LO  = 4'd3;
  localparam logic [3:0] S_THR_HI  = 4'd4;
  localparam logic [3:0] S_THR_END = 4'd5;
  localparam logic [3:0] S_GAIN    = 4'd6;
  localparam logic [3:0] S_DIV     = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  // configuration
  logic [LA_W-1:0]   lookahead;
  logic [COEF_W-1:0] attack;
  logic [COEF_W-1:0] release_coef;
  logic [CFG_W-1:0]  threshold;

  // control
  logic [3:0]    state;
  logic [AW-1:0] wp;
  logic [LA_W-1:0] fill;
  logic [SAMPLE_W-1:0] envelope;
  logic          lq_ok;
  logic [3:0]    k;
  logic [4:0]    bit_idx;

  // payload
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] diff;
  logic          rising;
  logic          y_ok;
  logic [AW-1:0] wp_cur;
  logic [SAMPLE_W-1:0] sample_hold;
  logic signed [SAMPLE_W-1:0] y;
  logic [6:0]    ip;
  logic [15:0]   frac;
  logic [30:0]   v;
  logic [46:0]   plo;
  logic [30:0]   lq;
  logic [40:0]   rem;
  logic [GAIN_W-1:0] quot;
  logic [GAIN_W-1:0] gain;
  logic signed [41:0] prod;

  // delay memory
  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  // accept-side combinational values
  logic          accept;
  logic [SAMPLE_W-1:0] mag_c;
  logic [LA_W-1:0] la_eff;
  logic [DW-1:0] rp_tmp;
  logic [AW-1:0] rp;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    mag_c = sample_in[SAMPLE_W-1] ? (~sample_in + 1'b1) : sample_in;
    if (lookahead == '0) begin
      la_eff = LA_W'(1);
    end else if ({1'b0, lookahead} > (LA_W+1)'(LA_MAX)) begin
      la_eff = LA_W'(LA_MAX);
    end else begin
      la_eff = lookahead;
    end
    rp_tmp = DW'(wp) - DW'(la_eff);
    if (rp_tmp[DW-1]) rp_tmp = rp_tmp + DW'(DELAY_DEPTH);
    rp = rp_tmp[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[rp];
    if (state == S_ENV) mem[wp_cur] <= sample_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead    <= LA_W'(64);
      attack       <= '0;
      release_coef <= 16'd65000;
      threshold    <= 16'hFF00;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOOKAHEAD: lookahead    <= cfg_data[LA_W-1:0];
        REG_ATTACK:    attack       <= cfg_data;
        REG_RELEASE:   release_coef <= cfg_data;
        REG_THRESHOLD: threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // combinational helpers for the working states
  logic [39:0] env_prod;
  logic [SAMPLE_W-1:0] env_new;
  logic [16:0] m_db;
  logic [34:0] x_full;
  logic [61:0] vhi;
  logic [61:0] vsum;
  logic [39:0] num;
  logic [40:0] den;
  logic [GAIN_W-1:0] quot_next;
  logic [40:0] rem_next;

  always_comb begin
    env_prod = (rising ? attack : release_coef) * diff;
    env_new  = rising ? (mag - env_prod[39:16]) : (mag + env_prod[39:16]);
    m_db     = threshold[15] ? (17'd0 - {threshold[15], threshold}) : 17'd0;
    x_full   = 35'(m_db) * 35'(LOG2_PER_DB) + 35'd2048;
    vhi      = 62'(v) * 62'(ROOT_TABLE[k][30:16]);
    vsum     = (vhi << 16) + 62'(plo);
    num      = 40'(lq) << 9;
    den      = 41'(envelope) << bit_idx;
    rem_next = rem;
    quot_next = quot;
    if (rem >= den) begin
      rem_next = rem - den;
      quot_next[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      envelope  <= '0;
      lq_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_OUT handles its own output register
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      if (cfg_write && cfg_index == REG_THRESHOLD) lq_ok <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            mag         <= mag_c;
            rising      <= envelope < mag_c;
            diff        <= (envelope < mag_c) ? (mag_c - envelope) : (envelope - mag_c);
            sample_hold <= sample_in;
            wp_cur      <= wp;
            y_ok        <= fill >= la_eff;
            fill        <= (fill >= la_eff) ? la_eff : fill + 1'b1;
            wp          <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
            state       <= S_ENV;
          end
        end
        S_ENV: begin
          envelope <= env_new;
          y        <= y_ok ? rd_data : '0;
          state    <= lq_ok ? S_GAIN : S_THR_X;
        end
        S_THR_X: begin
          ip    <= x_full[34:28];
          frac  <= x_full[27:12];
          v     <= 31'h4000_0000;
          k     <= '0;
          state <= S_THR_LO;
        end
        S_THR_LO: begin
          plo   <= 47'(v) * 47'(ROOT_TABLE[k][15:0]);
          state <= S_THR_HI;
        end
        S_THR_HI: begin
          if (frac[4'd15 - k]) v <= vsum[60:30];
          k     <= k + 1'b1;
          state <= (k == 4'd15) ? S_THR_END : S_THR_LO;
        end
        S_THR_END: begin
          lq    <= (ip > 7'd30) ? '0 : (v >> ip);
          lq_ok <= 1'b1;
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (envelope == '0 || {1'b0, num} >= {envelope, 17'd0}) begin
            gain  <= GAIN_UNITY;
            state <= S_MUL;
          end else begin
            rem     <= {1'b0, num};
            quot    <= '0;
            bit_idx <= 5'd16;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          quot    <= quot_next;
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            gain  <= (quot_next > GAIN_UNITY) ? GAIN_UNITY : quot_next;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 42'(y) * $signed({25'd0, gain});
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            sample_out   <= 24'((prod + 42'sd32768) >>> 16);
            gain_applied <= gain;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/lpl_checker.sv
// ---------------------------------------------------------------------------
// lpl_checker
// Port-level checks for the limiter, bound onto the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lookahead_peak_limiter_macros.svh"
module lpl_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [23:0] sample_out,
  input wire [16:0] gain_applied
);
  import lpl_pkg::*;

  // held result must not change
  `LPL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(gain_applied))
  // gain never exceeds unity
  `LPL_ASSERT_IMPL(a_gain_max, clk, rst, out_valid, gain_applied <= GAIN_UNITY)
  // one request in flight: busy right after a request is taken
  `LPL_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .sample_out(sample_out),
  .gain_applied(gain_applied)
);
`default_nettype wire
